@@ hw/rtl/rtc_pkg.sv @@
// Shared types, widths and constants for the rational tanh soft clipper.
// Used by rtc_front, rtc_poly, rtc_div and rational_tanh_soft_clipper.
// Depends on nothing else.
package rtc_pkg;

  // Default input width, Q15 with extended headroom.
  localparam int IN_WIDTH_DEF = 24;

  // Fraction bits of the internal Q16 values.
  localparam int FRAC = 16;

  // Inputs with |x| >= 2^20 (a >= 64) take the full-scale answer.
  localparam int BIG_SHIFT = 20;

  // Widths of the Horner terms, sized from the bound a < 64.
  localparam int A_W  = BIG_SHIFT + 2;
  localparam int T0_W = 23;
  localparam int T1_W = 30;
  localparam int T2_W = 36;
  localparam int P_W  = 42;
  localparam int D_W  = 43;

  // The last product is split over the two halves of a.
  localparam int A_LO_W = A_W / 2;
  localparam int A_HI_W = A_W - A_LO_W;

  // Quotient width; one quotient bit per fraction bit of the dividend.
  localparam int Q_W = FRAC;

  // Horner constants in Q16 and the dividend 24 * 32768 in Q16.
  localparam logic [T0_W-1:0] K3   = T0_W'(3 * 65536);
  localparam logic [T1_W-1:0] K6   = T1_W'(6 * 65536);
  localparam logic [T2_W-1:0] K12  = T2_W'(12 * 65536);
  localparam logic [P_W-1:0]  K24  = P_W'(24 * 65536);
  localparam logic [D_W-1:0]  NUMER = D_W'(64'd786432 << 16);

  // Output scale: 1.0 in Q15 and the largest positive sample.
  localparam logic [Q_W-1:0] ONE_Q15 = 16'h8000;
  localparam logic [Q_W-1:0] MAX_POS = 16'h7FFF;

  // Register stages of each part of the pipeline.
  localparam int FRONT_LAT = 1;
  localparam int POLY_LAT  = 6;
  localparam int DIV_LAT   = Q_W + 1;
  localparam int OUT_LAT   = 1;
  localparam int LATENCY   = FRONT_LAT + POLY_LAT + DIV_LAT + OUT_LAT;

  // Control that travels beside each word in the pipeline.
  typedef struct packed {
    logic valid;
    logic neg;
    logic big;
  } side_t;

endpackage

@@ hw/rtl/rtc_front.sv @@
// Front stage of the soft clipper: magnitude, sign, large-input flag,
// a = 4|x| in Q16 and the first Horner term a + 3.
// Depends on rtc_pkg.
module rtc_front #(
  parameter int IN_WIDTH = rtc_pkg::IN_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [IN_WIDTH-1:0] sample_in,
  output rtc_pkg::side_t             side,
  output logic [rtc_pkg::A_W-1:0]    a,
  output logic [rtc_pkg::T0_W-1:0]   t0
);
  import rtc_pkg::*;

  localparam int MAG_W = (IN_WIDTH > BIG_SHIFT) ? IN_WIDTH : BIG_SHIFT + 1;

  logic [IN_WIDTH-1:0] raw;
  logic [IN_WIDTH-1:0] mag;
  logic [MAG_W-1:0]    mag_ext;
  logic                big_next;
  logic [A_W-1:0]      a_next;
  logic [T0_W-1:0]     t0_next;

  // The most negative input keeps its magnitude exactly as an unsigned value.
  always_comb begin
    raw      = sample_in;
    mag      = raw[IN_WIDTH-1] ? IN_WIDTH'(~raw + 1'b1) : raw;
    mag_ext  = MAG_W'(mag);
    big_next = |mag_ext[MAG_W-1:BIG_SHIFT];
    a_next   = {mag_ext[BIG_SHIFT-1:0], 2'b00};
    t0_next  = T0_W'(a_next) + K3;
  end

  // Control and data registers; only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      side.valid <= 1'b0;
    end else begin
      side.valid <= start;
    end
    side.neg <= raw[IN_WIDTH-1];
    side.big <= big_next;
    a        <= a_next;
    t0       <= t0_next;
  end

endmodule

@@ hw/rtl/rtc_poly.sv @@
// Horner pipeline of the soft clipper: evaluates p = 24+a(12+a(6+a(3+a)))
// in Q16, each product floored back to Q16. Depends on rtc_pkg.
module rtc_poly (
  input  logic                     clk,
  input  logic                     rst,
  input  rtc_pkg::side_t           side_in,
  input  logic [rtc_pkg::A_W-1:0]  a_in,
  input  logic [rtc_pkg::T0_W-1:0] t0_in,
  output rtc_pkg::side_t           side_out,
  output logic [rtc_pkg::P_W-1:0]  p
);
  import rtc_pkg::*;

  side_t                  sd [POLY_LAT];
  logic [A_W-1:0]         a1, a2, a3, a4;
  logic [T0_W+A_W-1:0]    mul0;
  logic [T1_W-1:0]        t1;
  logic [T1_W+A_W-1:0]    mul1;
  logic [T2_W-1:0]        t2;
  logic [T2_W+A_LO_W-1:0] part_lo;
  logic [T2_W+A_HI_W-1:0] part_hi;
  logic [T2_W+A_W-1:0]    mul2;

  // Control shifts along with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < POLY_LAT; i++) begin
        sd[i].valid <= 1'b0;
      end
    end else begin
      sd[0] <= side_in;
      for (int i = 1; i < POLY_LAT; i++) begin
        sd[i] <= sd[i-1];
      end
    end
  end

  // Recombine the two partial products of the last multiplication.
  always_comb begin
    mul2 = {part_hi, A_LO_W'(0)} + (T2_W + A_W)'(part_lo);
  end

  // Alternating multiply and add stages.
  always_ff @(posedge clk) begin
    mul0    <= t0_in * a_in;
    a1      <= a_in;
    t1      <= T1_W'(mul0 >> FRAC) + K6;
    a2      <= a1;
    mul1    <= t1 * a2;
    a3      <= a2;
    t2      <= T2_W'(mul1 >> FRAC) + K12;
    a4      <= a3;
    part_lo <= t2 * a4[A_LO_W-1:0];
    part_hi <= t2 * a4[A_W-1:A_LO_W];
    p       <= P_W'(mul2 >> FRAC) + K24;
  end

  assign side_out = sd[POLY_LAT-1];

endmodule

@@ hw/rtl/rtc_div.sv @@
// Restoring divider pipeline of the soft clipper: q = (24*32768*65536 + p/2) / p,
// one quotient bit per stage. Depends on rtc_pkg.
module rtc_div (
  input  logic                    clk,
  input  logic                    rst,
  input  rtc_pkg::side_t          side_in,
  input  logic [rtc_pkg::P_W-1:0] p_in,
  output rtc_pkg::side_t          side_out,
  output logic [rtc_pkg::Q_W-1:0] q
);
  import rtc_pkg::*;

  side_t          sd  [Q_W+1];
  logic [P_W-1:0] rem [Q_W+1];
  logic [P_W-1:0] pd  [Q_W+1];
  logic [Q_W-1:0] dl  [Q_W+1];
  logic [Q_W-1:0] qq  [Q_W+1];
  logic [D_W-1:0] dividend;

  // Rounded dividend; its upper part is already below p, so the quotient fits Q_W bits.
  always_comb begin
    dividend = NUMER + D_W'(p_in >> 1);
  end

  // Stage that loads the divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      sd[0].valid <= 1'b0;
    end else begin
      sd[0] <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= P_W'(dividend[D_W-1:FRAC]);
    dl[0]  <= dividend[FRAC-1:0];
    pd[0]  <= p_in;
    qq[0]  <= '0;
  end

  // One shift, compare and subtract per stage.
  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [P_W:0] shifted;
    logic         fits;

    always_comb begin
      shifted = {rem[k], dl[k][Q_W-1]};
      fits    = shifted >= (P_W + 1)'(pd[k]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sd[k+1].valid <= 1'b0;
      end else begin
        sd[k+1] <= sd[k];
      end
    end

    always_ff @(posedge clk) begin
      rem[k+1] <= fits ? P_W'(shifted - (P_W + 1)'(pd[k])) : P_W'(shifted);
      dl[k+1]  <= {dl[k][Q_W-2:0], 1'b0};
      pd[k+1]  <= pd[k];
      qq[k+1]  <= {qq[k][Q_W-2:0], fits};
    end
  end

  assign side_out = sd[Q_W];
  assign q        = qq[Q_W];

endmodule

@@ hw/rtl/rational_tanh_soft_clipper.sv @@
// Top level of the rational tanh soft clipper: front stage, Horner pipeline,
// divider pipeline and the output register. Depends on rtc_pkg and its submodules.
//
//   port group            dir   word            handshake
//   start / sample_in     in    input sample    taken when start && !busy
//   done  / sample_out    out   output sample   one-cycle strobe on done
//
// Every sample passes through 25 register stages: one front stage, six Horner
// stages (three multiplications), seventeen divider stages (a load stage and
// one per quotient bit) and the output register; the divider is the deepest part.
// A new sample is taken in every cycle and busy stays low.
// Reset clears the valid bits only; the receiver cannot stall the pipeline.
module rational_tanh_soft_clipper #(
  parameter int IN_WIDTH = rtc_pkg::IN_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [IN_WIDTH-1:0] sample_in,
  output logic                       done,
  output logic signed [15:0]         sample_out
);
  import rtc_pkg::*;

  side_t           front_side;
  logic [A_W-1:0]  a;
  logic [T0_W-1:0] t0;
  side_t           poly_side;
  logic [P_W-1:0]  p;
  side_t           div_side;
  logic [Q_W-1:0]  q;
  logic [Q_W-1:0]  q_sat;
  logic [Q_W-1:0]  mag;
  logic [Q_W-1:0]  result;

  rtc_front #(
    .IN_WIDTH(IN_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .sample_in(sample_in),
    .side     (front_side),
    .a        (a),
    .t0       (t0)
  );

  rtc_poly u_poly (
    .clk     (clk),
    .rst     (rst),
    .side_in (front_side),
    .a_in    (a),
    .t0_in   (t0),
    .side_out(poly_side),
    .p       (p)
  );

  rtc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .side_in (poly_side),
    .p_in    (p),
    .side_out(div_side),
    .q       (q)
  );

  // The pipeline takes a word in every cycle.
  assign busy = 1'b0;

  // Magnitude 32768 - q, full scale for large inputs, then sign and saturation.
  always_comb begin
    q_sat = (q > ONE_Q15) ? ONE_Q15 : q;
    mag   = div_side.big ? ONE_Q15 : ONE_Q15 - q_sat;
    if (div_side.neg) begin
      result = Q_W'(~mag + 1'b1);
    end else begin
      result = (mag == ONE_Q15) ? MAX_POS : mag;
    end
  end

  // Output register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_side.valid;
    end
  end

  always_ff @(posedge clk) begin
    sample_out <= result;
  end

  // A result word appears only for an input word taken earlier that has passed every stage.
  a_done_aligned: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result strobe without a matching input word");

  // A zero input yields a zero output.
  a_zero_in_zero_out: assert property (@(posedge clk) disable iff (rst)
    (done && $past(start && (sample_in == '0), LATENCY)) |-> (sample_out == 16'sd0))
    else $error("zero input did not give zero output");

  // The output sign follows the input sign.
  a_neg_sign: assert property (@(posedge clk) disable iff (rst)
    (done && $past(start && sample_in[IN_WIDTH-1], LATENCY))
      |-> (sample_out[15] || (sample_out == 16'sd0)))
    else $error("negative input gave a positive output");

  a_pos_sign: assert property (@(posedge clk) disable iff (rst)
    (done && $past(start && !sample_in[IN_WIDTH-1], LATENCY)) |-> !sample_out[15])
    else $error("non-negative input gave a negative output");

endmodule

@@ tb/sv/tanh_clip_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the rational tanh soft clipper: predicts each output word
// from the accepted input word and compares it with what the block returns.
// Depends on rtc_pkg for the input width.
module tanh_clip_checker #(
  parameter int IN_W = rtc_pkg::IN_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   busy,
  input  logic signed [IN_W-1:0] sample_in,
  input  logic                   done,
  input  logic signed [15:0]     sample_out,
  output int                     mismatches,
  output int                     pending
);

  localparam longint unsigned ONE_Q16   = 64'd65536;
  localparam longint unsigned CLIP_A    = 64'd64 * ONE_Q16;
  localparam longint unsigned DIVIDEND  = 64'd786432 * ONE_Q16;
  localparam longint unsigned FULL_MAG  = 64'd32768;

  logic signed [15:0] clipped_q[$];
  int                 err_count;

  // Horner evaluation of 24+a(12+a(6+a(3+a))) with a in Q16; each product is
  // floored back to Q16 before the next constant is added.
  function automatic longint unsigned horner_q16(input longint unsigned a);
    longint unsigned acc;
    acc = a + 64'd3 * ONE_Q16;
    acc = ((acc * a) >> 16) + 64'd6 * ONE_Q16;
    acc = ((acc * a) >> 16) + 64'd12 * ONE_Q16;
    acc = ((acc * a) >> 16) + 64'd24 * ONE_Q16;
    return acc;
  endfunction

  // Soft-clipped output word for one input word.
  function automatic logic signed [15:0] clip_sample(input logic signed [IN_W-1:0] x);
    logic            neg;
    longint unsigned raw;
    longint unsigned mag;
    longint unsigned a;
    longint unsigned poly;
    longint unsigned corr;
    longint unsigned m;
    neg = x[IN_W-1];
    raw = 64'(unsigned'(x));
    mag = neg ? ((64'd1 << IN_W) - raw) : raw;
    a   = mag * 64'd4;
    if (a >= CLIP_A) begin
      // Large inputs go straight to full scale.
      m = FULL_MAG;
    end else begin
      poly = horner_q16(a);
      corr = (DIVIDEND + (poly >> 1)) / poly;
      if (corr > FULL_MAG) corr = FULL_MAG;
      m = FULL_MAG - corr;
    end
    if (neg) return 16'(64'h10000 - m);
    else     return (m > 64'd32767) ? 16'sh7FFF : 16'(m);
  endfunction

  // Queue a prediction per accepted input word and check every output word.
  always @(posedge clk) begin
    if (rst) begin
      clipped_q.delete();
      err_count = 0;
    end else begin
      if (done) begin
        if (clipped_q.size() == 0) begin
          if (err_count < 10)
            $display("ERROR: output word %0d with nothing expected", sample_out);
          err_count++;
        end else begin
          if (sample_out !== clipped_q[0]) begin
            if (err_count < 10)
              $display("ERROR: sample_out expected %0d got %0d", clipped_q[0], sample_out);
            err_count++;
          end
          void'(clipped_q.pop_front());
        end
      end
      if (start && !busy) clipped_q.push_back(clip_sample(sample_in));
    end
    mismatches <= err_count;
    pending    <= clipped_q.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Top of the soft clipper testbench: clock, reset, stimulus and verdict.
// Depends on rtc_pkg, rational_tanh_soft_clipper and tanh_clip_checker.
module testbench;

  localparam int IN_W       = rtc_pkg::IN_WIDTH_DEF;
  localparam int RAND_ITEMS = 1750;
  localparam int IDLE_LIMIT = 2000;
  localparam int BIG_MAG    = 1 << 20;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic signed [IN_W-1:0] sample_in;
  logic                   done;
  logic signed [15:0]     sample_out;
  int                     mismatches;
  int                     pending;
  int                     idle_cycles;
  logic                   burst_mode;

  rational_tanh_soft_clipper #(.IN_WIDTH(IN_W)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .sample_in(sample_in), .done(done), .sample_out(sample_out)
  );

  tanh_clip_checker #(.IN_W(IN_W)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .sample_in(sample_in), .done(done), .sample_out(sample_out),
    .mismatches(mismatches), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Watchdog: counts cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Offer one input word after a random gap (none in burst mode) and wait until it is taken.
  task automatic send_word(input logic signed [IN_W-1:0] v);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    sample_in <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Hold off the sender until every predicted word has come back.
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Random word: mostly the curved region and the full-scale threshold.
  function automatic logic signed [IN_W-1:0] random_word;
    int sel;
    int mag;
    sel = $urandom_range(0, 99);
    if (sel < 35)      mag = $urandom_range(0, 131071);
    else if (sel < 55) mag = $urandom_range(BIG_MAG - 64, BIG_MAG + 64);
    else if (sel < 75) mag = $urandom_range(0, BIG_MAG - 1);
    else               return IN_W'($urandom());
    return $urandom_range(0, 1) ? IN_W'(-mag) : IN_W'(mag);
  endfunction

  initial begin
    int directed[$];
    rst        <= 1'b1;
    start      <= 1'b0;
    sample_in  <= '0;
    burst_mode = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed words: zero, tiny, unity, around the threshold, both extremes.
    directed = '{0, 1, -1, 2, -2, 16384, -16384, 32768, -32768, 65536, -65536,
                 100000, -100000, BIG_MAG - 2, -(BIG_MAG - 2), BIG_MAG - 1,
                 -(BIG_MAG - 1), BIG_MAG, -BIG_MAG, BIG_MAG + 1, -(BIG_MAG + 1),
                 8388607, -8388608, 8388606, -8388607};
    foreach (directed[i]) send_word(IN_W'(directed[i]));
    drain();

    // Random words, with zero-gap stretches switched in now and then.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 100 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      if (n == RAND_ITEMS / 2) drain();
      send_word(random_word());
    end
    start <= 1'b0;

    // Let the last words leave the pipeline, then give the verdict.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (rtc_pkg::LATENCY + 5) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
